[src/assert_macros.svh]
// Assertion macros shared by the register-access bus master RTL.
// Needs i_clk and i_rst_n in the scope of each module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/i2cra_pkg.sv]
// Shared types and constants for the register-access bus master.
// No dependencies; used by i2cra_seq, the top level and the testbench.
`default_nettype none

package i2cra_pkg;

    localparam int ADDR_W    = 7;
    localparam int PHASE_W   = 10;
    localparam int BYTE_W    = 8;
    localparam int BIT_CNT_W = 4;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX  = 4'd7;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RST = 7'd100;
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST    = 10'd5;

    // Bus sequence steps, one-hot.
    typedef enum logic [18:0] {
        ST_IDLE         = 19'h00001,
        ST_START_HIGH   = 19'h00002,
        ST_START_FALL   = 19'h00004,
        ST_ADRW_LOW     = 19'h00008,
        ST_ADRW_HIGH    = 19'h00010,
        ST_REG_LOW      = 19'h00020,
        ST_REG_HIGH     = 19'h00040,
        ST_VAL_LOW      = 19'h00080,
        ST_VAL_HIGH     = 19'h00100,
        ST_RESTART_LOW  = 19'h00200,
        ST_RESTART_HIGH = 19'h00400,
        ST_RESTART_FALL = 19'h00800,
        ST_ADRR_LOW     = 19'h01000,
        ST_ADRR_HIGH    = 19'h02000,
        ST_RD_LOW       = 19'h04000,
        ST_RD_HIGH      = 19'h08000,
        ST_STOP_LOW     = 19'h10000,
        ST_STOP_HIGH    = 19'h20000,
        ST_STOP_END     = 19'h40000
    } t_step;

    // Pin drive and status produced for one tick.
    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_enable;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] read_data;
        logic              ack_error;
    } t_result;

endpackage

`default_nettype wire

[src/i2cra_seq.sv]
// Bus sequencer: holds the transaction state and advances it one tick per beat.
// Depends on i2cra_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2cra_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_step,
    input  wire logic                            i_start_request,
    input  wire logic                            i_is_read,
    input  wire logic [i2cra_pkg::BYTE_W-1:0]    i_reg_addr,
    input  wire logic [i2cra_pkg::BYTE_W-1:0]    i_write_data,
    input  wire logic                            i_sda_in,
    input  wire logic [i2cra_pkg::ADDR_W-1:0]    i_device_address,
    input  wire logic [i2cra_pkg::PHASE_W-1:0]   i_phase_ticks,
    output i2cra_pkg::t_result                   o_res
);

    i2cra_pkg::t_step                       r_step,  n_step;
    logic [i2cra_pkg::PHASE_W-1:0]          r_tick,  n_tick;
    logic [i2cra_pkg::BIT_CNT_W-1:0]        r_bit_cnt, n_bit_cnt;
    logic [i2cra_pkg::BYTE_W-1:0]           r_shift, n_shift;
    logic [i2cra_pkg::BYTE_W-1:0]           r_lat_reg, n_lat_reg;
    logic [i2cra_pkg::BYTE_W-1:0]           r_lat_val, n_lat_val;
    logic                                   r_lat_dir, n_lat_dir;
    logic [i2cra_pkg::BYTE_W-1:0]           r_rx, n_rx;
    logic                                   r_nack, n_nack;

    logic [i2cra_pkg::PHASE_W-1:0]          plen;
    logic                                   last;
    logic                                   bit_pending;
    logic [i2cra_pkg::BYTE_W-1:0]           shift_in;

    // Phase length and per-tick flags.
    always_comb begin
        plen        = (i_phase_ticks == '0) ? i2cra_pkg::PHASE_W'(1) : i_phase_ticks;
        last        = (r_tick >= (plen - i2cra_pkg::PHASE_W'(1)));
        bit_pending = (r_bit_cnt < i2cra_pkg::BITS_PER_BYTE);
        shift_in    = {r_shift[i2cra_pkg::BYTE_W-2:0], i_sda_in};
    end

    // Pin drive for this tick, taken from the state before the update.
    always_comb begin
        o_res            = '0;
        o_res.scl_level  = 1'b1;
        o_res.sda_level  = 1'b1;
        o_res.sda_enable = 1'b1;
        o_res.busy       = (r_step != i2cra_pkg::ST_IDLE);
        o_res.read_data  = r_rx;
        o_res.ack_error  = r_nack;
        unique case (r_step)
            i2cra_pkg::ST_ADRW_LOW, i2cra_pkg::ST_REG_LOW,
            i2cra_pkg::ST_VAL_LOW,  i2cra_pkg::ST_ADRR_LOW: begin
                o_res.scl_level = 1'b0;
                if (bit_pending) begin
                    o_res.sda_level = r_shift[i2cra_pkg::BYTE_W-1];
                end else begin
                    o_res.sda_enable = 1'b0;
                end
            end
            i2cra_pkg::ST_ADRW_HIGH, i2cra_pkg::ST_REG_HIGH,
            i2cra_pkg::ST_VAL_HIGH,  i2cra_pkg::ST_ADRR_HIGH: begin
                if (bit_pending) begin
                    o_res.sda_level = r_shift[i2cra_pkg::BYTE_W-1];
                end else begin
                    o_res.sda_enable = 1'b0;
                end
            end
            i2cra_pkg::ST_START_FALL, i2cra_pkg::ST_RESTART_FALL: begin
                o_res.sda_level = 1'b0;
            end
            i2cra_pkg::ST_RESTART_LOW: begin
                o_res.scl_level = 1'b0;
            end
            i2cra_pkg::ST_RD_LOW: begin
                o_res.scl_level = 1'b0;
                if (bit_pending) o_res.sda_enable = 1'b0;
            end
            i2cra_pkg::ST_RD_HIGH: begin
                if (bit_pending) o_res.sda_enable = 1'b0;
            end
            i2cra_pkg::ST_STOP_LOW: begin
                o_res.scl_level = 1'b0;
                o_res.sda_level = 1'b0;
            end
            i2cra_pkg::ST_STOP_HIGH: begin
                o_res.sda_level = 1'b0;
            end
            i2cra_pkg::ST_STOP_END: begin
                o_res.done = last;
            end
            default: begin
            end
        endcase
    end

    // Next state: latch a request when idle, otherwise count ticks and
    // step the sequence at the end of each phase.
    always_comb begin
        n_step    = r_step;
        n_tick    = r_tick;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_lat_reg = r_lat_reg;
        n_lat_val = r_lat_val;
        n_lat_dir = r_lat_dir;
        n_rx      = r_rx;
        n_nack    = r_nack;
        if (r_step == i2cra_pkg::ST_IDLE) begin
            n_tick = '0;
            if (i_start_request) begin
                n_lat_dir = i_is_read;
                n_lat_reg = i_reg_addr;
                n_lat_val = i_write_data;
                n_nack    = 1'b0;
                n_bit_cnt = '0;
                n_step    = i2cra_pkg::ST_START_HIGH;
            end
        end else if (last) begin
            n_tick = '0;
            unique case (r_step)
                i2cra_pkg::ST_START_HIGH:   n_step = i2cra_pkg::ST_START_FALL;
                i2cra_pkg::ST_START_FALL: begin
                    n_step    = i2cra_pkg::ST_ADRW_LOW;
                    n_shift   = {i_device_address, 1'b0};
                    n_bit_cnt = '0;
                end
                i2cra_pkg::ST_RESTART_LOW:  n_step = i2cra_pkg::ST_RESTART_HIGH;
                i2cra_pkg::ST_RESTART_HIGH: n_step = i2cra_pkg::ST_RESTART_FALL;
                i2cra_pkg::ST_RESTART_FALL: begin
                    n_step    = i2cra_pkg::ST_ADRR_LOW;
                    n_shift   = {i_device_address, 1'b1};
                    n_bit_cnt = '0;
                end
                i2cra_pkg::ST_ADRW_LOW:     n_step = i2cra_pkg::ST_ADRW_HIGH;
                i2cra_pkg::ST_REG_LOW:      n_step = i2cra_pkg::ST_REG_HIGH;
                i2cra_pkg::ST_VAL_LOW:      n_step = i2cra_pkg::ST_VAL_HIGH;
                i2cra_pkg::ST_ADRR_LOW:     n_step = i2cra_pkg::ST_ADRR_HIGH;
                i2cra_pkg::ST_RD_LOW:       n_step = i2cra_pkg::ST_RD_HIGH;
                i2cra_pkg::ST_ADRW_HIGH: begin
                    if (bit_pending) begin
                        n_shift   = {r_shift[i2cra_pkg::BYTE_W-2:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 1'b1;
                        n_step    = i2cra_pkg::ST_ADRW_LOW;
                    end else begin
                        n_nack    = r_nack | i_sda_in;
                        n_step    = i2cra_pkg::ST_REG_LOW;
                        n_shift   = r_lat_reg;
                        n_bit_cnt = '0;
                    end
                end
                i2cra_pkg::ST_REG_HIGH: begin
                    if (bit_pending) begin
                        n_shift   = {r_shift[i2cra_pkg::BYTE_W-2:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 1'b1;
                        n_step    = i2cra_pkg::ST_REG_LOW;
                    end else begin
                        n_nack    = r_nack | i_sda_in;
                        n_bit_cnt = '0;
                        if (r_lat_dir) begin
                            n_step = i2cra_pkg::ST_RESTART_LOW;
                        end else begin
                            n_step  = i2cra_pkg::ST_VAL_LOW;
                            n_shift = r_lat_val;
                        end
                    end
                end
                i2cra_pkg::ST_VAL_HIGH: begin
                    if (bit_pending) begin
                        n_shift   = {r_shift[i2cra_pkg::BYTE_W-2:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 1'b1;
                        n_step    = i2cra_pkg::ST_VAL_LOW;
                    end else begin
                        n_nack    = r_nack | i_sda_in;
                        n_step    = i2cra_pkg::ST_STOP_LOW;
                        n_bit_cnt = '0;
                    end
                end
                i2cra_pkg::ST_ADRR_HIGH: begin
                    if (bit_pending) begin
                        n_shift   = {r_shift[i2cra_pkg::BYTE_W-2:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 1'b1;
                        n_step    = i2cra_pkg::ST_ADRR_LOW;
                    end else begin
                        n_nack    = r_nack | i_sda_in;
                        n_step    = i2cra_pkg::ST_RD_LOW;
                        n_shift   = '0;
                        n_bit_cnt = '0;
                    end
                end
                i2cra_pkg::ST_RD_HIGH: begin
                    if (bit_pending) begin
                        n_shift   = shift_in;
                        n_bit_cnt = r_bit_cnt + 1'b1;
                        if (r_bit_cnt == i2cra_pkg::LAST_BIT_IDX) n_rx = shift_in;
                        n_step    = i2cra_pkg::ST_RD_LOW;
                    end else begin
                        n_step    = i2cra_pkg::ST_STOP_LOW;
                        n_bit_cnt = '0;
                    end
                end
                i2cra_pkg::ST_STOP_LOW:     n_step = i2cra_pkg::ST_STOP_HIGH;
                i2cra_pkg::ST_STOP_HIGH:    n_step = i2cra_pkg::ST_STOP_END;
                default:                    n_step = i2cra_pkg::ST_IDLE;
            endcase
        end else begin
            n_tick = r_tick + i2cra_pkg::PHASE_W'(1);
        end
    end

    // State registers advance once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= i2cra_pkg::ST_IDLE;
            r_tick    <= '0;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_lat_reg <= '0;
            r_lat_val <= '0;
            r_lat_dir <= 1'b0;
            r_rx      <= '0;
            r_nack    <= 1'b0;
        end else if (i_step) begin
            r_step    <= n_step;
            r_tick    <= n_tick;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_lat_reg <= n_lat_reg;
            r_lat_val <= n_lat_val;
            r_lat_dir <= n_lat_dir;
            r_rx      <= n_rx;
            r_nack    <= n_nack;
        end
    end

    // The bit counter covers eight data bits plus the acknowledge slot.
    `ASSERT_IMPLY(a_bit_cnt_range, 1'b1, r_bit_cnt <= i2cra_pkg::BITS_PER_BYTE, "bit counter overran")
    // A request taken while idle opens the START phase with a fresh count.
    `ASSERT_NEXT(a_start_taken, i_step && (r_step == i2cra_pkg::ST_IDLE) && i_start_request, (r_step == i2cra_pkg::ST_START_HIGH) && (r_tick == '0), "request not started")
    // The final STOP tick returns the sequencer to idle.
    `ASSERT_NEXT(a_stop_to_idle, i_step && o_res.done, r_step == i2cra_pkg::ST_IDLE, "no idle after STOP")

endmodule

`default_nettype wire

[src/i2c_register_access_master.sv]
// Top level of the register-access bus master: configuration registers,
// beat handshake and result register. Depends on i2cra_pkg, i2cra_seq and assert_macros.svh.
// A result is registered and becomes valid in the cycle after its tick beat is accepted.
// Throughput: one tick per cycle while the receiver takes results; the result register frees as it is taken.
// Reset (synchronous, active low) returns the sequencer to idle, where it drives SCL and SDA high,
// with device address 100 and 5 ticks per SCL half period.
`default_nettype none
`include "assert_macros.svh"

module i2c_register_access_master (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [i2cra_pkg::PHASE_W-1:0]   i_cfg_data,
    // Tick input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_start_request,
    input  wire logic                            i_is_read,
    input  wire logic [i2cra_pkg::BYTE_W-1:0]    i_reg_addr,
    input  wire logic [i2cra_pkg::BYTE_W-1:0]    i_write_data,
    input  wire logic                            i_sda_in,
    // Result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_scl_level,
    output logic                                 o_sda_level,
    output logic                                 o_sda_enable,
    output logic                                 o_busy_res,
    output logic                                 o_done_res,
    output logic [i2cra_pkg::BYTE_W-1:0]         o_read_data,
    output logic                                 o_ack_error
);

    logic [i2cra_pkg::ADDR_W-1:0]   r_device_address;
    logic [i2cra_pkg::PHASE_W-1:0]  r_phase_ticks;
    logic                           r_out_valid;
    i2cra_pkg::t_result             r_res;
    i2cra_pkg::t_result             seq_res;
    logic                           in_beat;

    // Take a new beat whenever the result register is empty or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= i2cra_pkg::DEVICE_ADDRESS_RST;
            r_phase_ticks    <= i2cra_pkg::PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cra_pkg::CFG_DEVICE_ADDRESS:
                    r_device_address <= i_cfg_data[i2cra_pkg::ADDR_W-1:0];
                i2cra_pkg::CFG_PHASE_TICKS:
                    r_phase_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    i2cra_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_beat),
        .i_start_request  (i_start_request),
        .i_is_read        (i_is_read),
        .i_reg_addr       (i_reg_addr),
        .i_write_data     (i_write_data),
        .i_sda_in         (i_sda_in),
        .i_device_address (r_device_address),
        .i_phase_ticks    (r_phase_ticks),
        .o_res            (seq_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_res <= seq_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_level  = r_res.scl_level;
    assign o_sda_level  = r_res.sda_level;
    assign o_sda_enable = r_res.sda_enable;
    assign o_busy_res   = r_res.busy;
    assign o_done_res   = r_res.done;
    assign o_read_data  = r_res.read_data;
    assign o_ack_error  = r_res.ack_error;

    // An idle bus leaves both lines high and driven.
    `ASSERT_IMPLY(a_idle_bus, o_out_valid && !o_busy_res, o_scl_level && o_sda_level && o_sda_enable, "idle bus not high")
    // A released SDA always reads as a high drive level.
    `ASSERT_IMPLY(a_released_high, o_out_valid && !o_sda_enable, o_sda_level && o_busy_res, "released SDA driven low")
    // Done marks the end of STOP, with both lines high.
    `ASSERT_IMPLY(a_done_stop, o_out_valid && o_done_res, o_busy_res && o_scl_level && o_sda_level, "done outside STOP")

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the register-access bus master: drives tick beats,
// predicts every result beat with a cycle model of the bus sequencer and compares.
// Depends on i2cra_pkg and the i2c_register_access_master RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TOTAL_TICKS = 1650;
    localparam int QUIET_TAIL  = 300;
    localparam int NO_CAP      = 1 << 30;

    // Cycle model of the bus sequencer plus the queue of result beats still owed.
    class i2c_tick_scoreboard;
        logic [i2cra_pkg::ADDR_W-1:0]    dev_addr;
        logic [i2cra_pkg::PHASE_W-1:0]   phase_len;
        i2cra_pkg::t_step                step;
        logic [i2cra_pkg::PHASE_W-1:0]   tick_cnt;
        logic [i2cra_pkg::BIT_CNT_W-1:0] bit_cnt;
        logic [i2cra_pkg::BYTE_W-1:0]    shifter;
        logic [i2cra_pkg::BYTE_W-1:0]    reg_latch;
        logic [i2cra_pkg::BYTE_W-1:0]    val_latch;
        logic [i2cra_pkg::BYTE_W-1:0]    rx_byte;
        logic                            dir_latch;
        logic                            nack;
        i2cra_pkg::t_result              expected_pins[$];
        int                              error_count;
        int                              ticks_seen;

        function void power_on();
            dev_addr    = i2cra_pkg::DEVICE_ADDRESS_RST;
            phase_len   = i2cra_pkg::PHASE_TICKS_RST;
            step        = i2cra_pkg::ST_IDLE;
            tick_cnt    = '0;
            bit_cnt     = '0;
            shifter     = '0;
            reg_latch   = '0;
            val_latch   = '0;
            rx_byte     = '0;
            dir_latch   = 1'b0;
            nack        = 1'b0;
            error_count = 0;
            ticks_seen  = 0;
        endfunction

        function void set_register(logic idx, logic [i2cra_pkg::PHASE_W-1:0] data);
            if (idx == i2cra_pkg::CFG_DEVICE_ADDRESS) begin
                dev_addr = data[i2cra_pkg::ADDR_W-1:0];
            end else begin
                phase_len = data;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function void load_byte(i2cra_pkg::t_step next_step,
                               logic [i2cra_pkg::BYTE_W-1:0] value);
            step    = next_step;
            shifter = value;
            bit_cnt = '0;
        endfunction

        // Level the target side puts on SDA for the current tick.
        function logic sda_for(int nack_pct, logic [i2cra_pkg::BYTE_W-1:0] rx);
            case (step)
                i2cra_pkg::ST_ADRW_LOW, i2cra_pkg::ST_ADRW_HIGH,
                i2cra_pkg::ST_REG_LOW, i2cra_pkg::ST_REG_HIGH,
                i2cra_pkg::ST_VAL_LOW, i2cra_pkg::ST_VAL_HIGH,
                i2cra_pkg::ST_ADRR_LOW, i2cra_pkg::ST_ADRR_HIGH: begin
                    if (bit_cnt >= i2cra_pkg::BITS_PER_BYTE) begin
                        return $urandom_range(0, 99) < nack_pct;
                    end
                end
                i2cra_pkg::ST_RD_LOW, i2cra_pkg::ST_RD_HIGH: begin
                    if (bit_cnt < i2cra_pkg::BITS_PER_BYTE) begin
                        return rx[i2cra_pkg::LAST_BIT_IDX - bit_cnt];
                    end
                end
                default: ;
            endcase
            return 1'($urandom_range(0, 1));
        endfunction

        // Move on from a step whose phase has run out.
        function void end_phase(logic sda);
            case (step)
                i2cra_pkg::ST_START_HIGH:   step = i2cra_pkg::ST_START_FALL;
                i2cra_pkg::ST_START_FALL:
                    load_byte(i2cra_pkg::ST_ADRW_LOW, {dev_addr, 1'b0});
                i2cra_pkg::ST_RESTART_LOW:  step = i2cra_pkg::ST_RESTART_HIGH;
                i2cra_pkg::ST_RESTART_HIGH: step = i2cra_pkg::ST_RESTART_FALL;
                i2cra_pkg::ST_RESTART_FALL:
                    load_byte(i2cra_pkg::ST_ADRR_LOW, {dev_addr, 1'b1});
                i2cra_pkg::ST_ADRW_LOW:     step = i2cra_pkg::ST_ADRW_HIGH;
                i2cra_pkg::ST_REG_LOW:      step = i2cra_pkg::ST_REG_HIGH;
                i2cra_pkg::ST_VAL_LOW:      step = i2cra_pkg::ST_VAL_HIGH;
                i2cra_pkg::ST_ADRR_LOW:     step = i2cra_pkg::ST_ADRR_HIGH;
                i2cra_pkg::ST_RD_LOW:       step = i2cra_pkg::ST_RD_HIGH;
                i2cra_pkg::ST_ADRW_HIGH, i2cra_pkg::ST_REG_HIGH,
                i2cra_pkg::ST_VAL_HIGH, i2cra_pkg::ST_ADRR_HIGH: begin
                    if (bit_cnt < i2cra_pkg::BITS_PER_BYTE) begin
                        // Next bit of the byte goes out in a fresh low phase.
                        shifter = shifter << 1;
                        bit_cnt = bit_cnt + 1'b1;
                        case (step)
                            i2cra_pkg::ST_ADRW_HIGH: step = i2cra_pkg::ST_ADRW_LOW;
                            i2cra_pkg::ST_REG_HIGH:  step = i2cra_pkg::ST_REG_LOW;
                            i2cra_pkg::ST_VAL_HIGH:  step = i2cra_pkg::ST_VAL_LOW;
                            default:                 step = i2cra_pkg::ST_ADRR_LOW;
                        endcase
                    end else begin
                        // Acknowledge slot: a high level counts as a NACK.
                        if (sda) begin
                            nack = 1'b1;
                        end
                        case (step)
                            i2cra_pkg::ST_ADRW_HIGH:
                                load_byte(i2cra_pkg::ST_REG_LOW, reg_latch);
                            i2cra_pkg::ST_REG_HIGH: begin
                                if (dir_latch) begin
                                    step    = i2cra_pkg::ST_RESTART_LOW;
                                    bit_cnt = '0;
                                end else begin
                                    load_byte(i2cra_pkg::ST_VAL_LOW, val_latch);
                                end
                            end
                            i2cra_pkg::ST_VAL_HIGH: begin
                                step    = i2cra_pkg::ST_STOP_LOW;
                                bit_cnt = '0;
                            end
                            default: load_byte(i2cra_pkg::ST_RD_LOW, '0);
                        endcase
                    end
                end
                i2cra_pkg::ST_RD_HIGH: begin
                    if (bit_cnt < i2cra_pkg::BITS_PER_BYTE) begin
                        shifter = {shifter[i2cra_pkg::BYTE_W-2:0], sda};
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt == i2cra_pkg::BITS_PER_BYTE) begin
                            rx_byte = shifter;
                        end
                        step = i2cra_pkg::ST_RD_LOW;
                    end else begin
                        step    = i2cra_pkg::ST_STOP_LOW;
                        bit_cnt = '0;
                    end
                end
                i2cra_pkg::ST_STOP_LOW:  step = i2cra_pkg::ST_STOP_HIGH;
                i2cra_pkg::ST_STOP_HIGH: step = i2cra_pkg::ST_STOP_END;
                default:                 step = i2cra_pkg::ST_IDLE;
            endcase
        endfunction

        // Outputs of one tick come from the state before it, then the state advances.
        function i2cra_pkg::t_result predict_tick(logic start, logic rd,
                                                  logic [i2cra_pkg::BYTE_W-1:0] rg,
                                                  logic [i2cra_pkg::BYTE_W-1:0] vl,
                                                  logic sda);
            i2cra_pkg::t_result r;
            int                 plen;
            bit                 phase_end;
            plen        = (phase_len == 0) ? 1 : int'(phase_len);
            phase_end   = int'(tick_cnt) >= plen - 1;
            r.scl_level  = 1'b1;
            r.sda_level  = 1'b1;
            r.sda_enable = 1'b1;
            r.done       = 1'b0;
            case (step)
                i2cra_pkg::ST_ADRW_LOW, i2cra_pkg::ST_REG_LOW,
                i2cra_pkg::ST_VAL_LOW, i2cra_pkg::ST_ADRR_LOW,
                i2cra_pkg::ST_ADRW_HIGH, i2cra_pkg::ST_REG_HIGH,
                i2cra_pkg::ST_VAL_HIGH, i2cra_pkg::ST_ADRR_HIGH: begin
                    r.scl_level = (step == i2cra_pkg::ST_ADRW_HIGH ||
                                   step == i2cra_pkg::ST_REG_HIGH ||
                                   step == i2cra_pkg::ST_VAL_HIGH ||
                                   step == i2cra_pkg::ST_ADRR_HIGH);
                    if (bit_cnt < i2cra_pkg::BITS_PER_BYTE) begin
                        r.sda_level = shifter[i2cra_pkg::BYTE_W-1];
                    end else begin
                        r.sda_enable = 1'b0;
                    end
                end
                i2cra_pkg::ST_START_FALL, i2cra_pkg::ST_RESTART_FALL: r.sda_level = 1'b0;
                i2cra_pkg::ST_RESTART_LOW: r.scl_level = 1'b0;
                i2cra_pkg::ST_RD_LOW: begin
                    r.scl_level = 1'b0;
                    r.sda_enable = !(bit_cnt < i2cra_pkg::BITS_PER_BYTE);
                end
                i2cra_pkg::ST_RD_HIGH: r.sda_enable = !(bit_cnt < i2cra_pkg::BITS_PER_BYTE);
                i2cra_pkg::ST_STOP_LOW: begin
                    r.scl_level = 1'b0;
                    r.sda_level = 1'b0;
                end
                i2cra_pkg::ST_STOP_HIGH: r.sda_level = 1'b0;
                i2cra_pkg::ST_STOP_END:  r.done = phase_end;
                default: ;
            endcase
            r.busy      = (step != i2cra_pkg::ST_IDLE);
            r.read_data = rx_byte;
            r.ack_error = nack;

            if (step == i2cra_pkg::ST_IDLE) begin
                tick_cnt = '0;
                if (start) begin
                    dir_latch = rd;
                    reg_latch = rg;
                    val_latch = vl;
                    nack      = 1'b0;
                    bit_cnt   = '0;
                    step      = i2cra_pkg::ST_START_HIGH;
                end
            end else if (phase_end) begin
                tick_cnt = '0;
                if (step == i2cra_pkg::ST_STOP_END) begin
                    step = i2cra_pkg::ST_IDLE;
                end else begin
                    end_phase(sda);
                end
            end else begin
                tick_cnt = tick_cnt + 1'b1;
            end
            return r;
        endfunction

        function void note_tick(logic start, logic rd, logic [i2cra_pkg::BYTE_W-1:0] rg,
                                logic [i2cra_pkg::BYTE_W-1:0] vl, logic sda);
            expected_pins.push_back(predict_tick(start, rd, rg, vl, sda));
            ticks_seen++;
        endfunction

        function void match_field(string name, logic [i2cra_pkg::BYTE_W-1:0] want,
                                  logic [i2cra_pkg::BYTE_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(i2cra_pkg::t_result got);
            i2cra_pkg::t_result want;
            if (expected_pins.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %p", $time, got);
                error_count++;
                return;
            end
            want = expected_pins.pop_front();
            match_field("scl_level", i2cra_pkg::BYTE_W'(want.scl_level),
                        i2cra_pkg::BYTE_W'(got.scl_level));
            match_field("sda_level", i2cra_pkg::BYTE_W'(want.sda_level),
                        i2cra_pkg::BYTE_W'(got.sda_level));
            match_field("sda_enable", i2cra_pkg::BYTE_W'(want.sda_enable),
                        i2cra_pkg::BYTE_W'(got.sda_enable));
            match_field("busy_res", i2cra_pkg::BYTE_W'(want.busy),
                        i2cra_pkg::BYTE_W'(got.busy));
            match_field("done_res", i2cra_pkg::BYTE_W'(want.done),
                        i2cra_pkg::BYTE_W'(got.done));
            match_field("read_data", want.read_data, got.read_data);
            match_field("ack_error", i2cra_pkg::BYTE_W'(want.ack_error),
                        i2cra_pkg::BYTE_W'(got.ack_error));
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic                            i_cfg_index;
    logic [i2cra_pkg::PHASE_W-1:0]   i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_start_request;
    logic                            i_is_read;
    logic [i2cra_pkg::BYTE_W-1:0]    i_reg_addr;
    logic [i2cra_pkg::BYTE_W-1:0]    i_write_data;
    logic                            i_sda_in;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic                            o_scl_level;
    logic                            o_sda_level;
    logic                            o_sda_enable;
    logic                            o_busy_res;
    logic                            o_done_res;
    logic [i2cra_pkg::BYTE_W-1:0]    o_read_data;
    logic                            o_ack_error;

    i2c_tick_scoreboard sb;
    bit  tx_idling;
    bit  rx_idling;
    bit  mid_cfg;
    int  rx_hold;
    int  rx_stall;
    int  cycle_count;

    i2c_register_access_master uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_request (i_start_request),
        .i_is_read       (i_is_read),
        .i_reg_addr      (i_reg_addr),
        .i_write_data    (i_write_data),
        .i_sda_in        (i_sda_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scl_level     (o_scl_level),
        .o_sda_level     (o_sda_level),
        .o_sda_enable    (o_sda_enable),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_read_data     (o_read_data),
        .o_ack_error     (o_ack_error)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Every result beat taken by the receiver is checked against the model.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            sb.check_result({o_scl_level, o_sda_level, o_sda_enable, o_busy_res,
                             o_done_res, o_read_data, o_ack_error});
        end
    end

    // Receiver: random stall bursts, plus long holds requested by the stimulus.
    initial begin
        i_out_ready = 1'b0;
        rx_hold     = 0;
        rx_stall    = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                i_out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                i_out_ready <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 5) == 0) begin
                rx_stall = $urandom_range(0, 7);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one tick beat, with an optional idle burst first, and wait for it to be taken.
    task automatic send_tick(input logic st, input logic rd,
                             input logic [i2cra_pkg::BYTE_W-1:0] rg,
                             input logic [i2cra_pkg::BYTE_W-1:0] vl, input logic sda);
        int gap;
        gap = (tx_idling && $urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_start_request <= st;
        i_is_read       <= rd;
        i_reg_addr      <= rg;
        i_write_data    <= vl;
        i_sda_in        <= sda;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_tick(st, rd, rg, vl, sda);
    endtask

    // Stop offering beats until every expected result beat has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // One register write with nothing in flight; write enable is dropped again before the task returns.
    task automatic write_cfg(input logic idx, input logic [i2cra_pkg::PHASE_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, data);
        @(posedge i_clk);
    endtask

    // Request tick; only called while the model says the bus is idle.
    task automatic start_transaction(input logic rd, input logic [i2cra_pkg::BYTE_W-1:0] rg,
                                     input logic [i2cra_pkg::BYTE_W-1:0] vl);
        send_tick(1'b1, rd, rg, vl, 1'($urandom_range(0, 1)));
    endtask

    // Clock the bus until it is idle again or the cap runs out. Requests and
    // payload during busy ticks are random noise the block has to ignore.
    task automatic run_bus(input logic [i2cra_pkg::BYTE_W-1:0] rx, input int nack_pct,
                           input int max_ticks);
        int n;
        n = 0;
        while (sb.step != i2cra_pkg::ST_IDLE && n < max_ticks) begin
            if (mid_cfg && $urandom_range(0, 499) == 0) begin
                write_cfg(i2cra_pkg::CFG_PHASE_TICKS,
                          i2cra_pkg::PHASE_W'($urandom_range(0, 3)));
            end
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      i2cra_pkg::BYTE_W'($urandom_range(0, 255)),
                      i2cra_pkg::BYTE_W'($urandom_range(0, 255)),
                      sb.sda_for(nack_pct, rx));
            n++;
        end
    endtask

    // Main stimulus.
    initial begin
        int                              goal;
        int                              next_cfg;
        int                              kind;
        bit                              quiet;
        logic [2:0]                      junk;
        logic [i2cra_pkg::ADDR_W-1:0]    dev;
        logic [i2cra_pkg::PHASE_W-1:0]   plen;

        sb = new;
        sb.power_on();
        cycle_count     = 0;
        tx_idling       = 1'b1;
        rx_idling       = 1'b1;
        mid_cfg         = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = i2cra_pkg::CFG_DEVICE_ADDRESS;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_start_request = 1'b0;
        i_is_read       = 1'b0;
        i_reg_addr      = '0;
        i_write_data    = '0;
        i_sda_in        = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset configuration, a plain write of all zeros.
        start_transaction(1'b0, 8'h00, 8'h00);
        run_bus(8'h00, 0, NO_CAP);

        // Shortest phase, lowest address, all-ones write under a long receiver hold.
        write_cfg(i2cra_pkg::CFG_PHASE_TICKS, 10'd1);
        write_cfg(i2cra_pkg::CFG_DEVICE_ADDRESS, 10'd0);
        rx_hold = 60;
        start_transaction(1'b0, 8'hFF, 8'hFF);
        run_bus(8'h00, 0, NO_CAP);

        // Reads at the highest address: all-ones data, then all-zeros with every slot NACKed.
        write_cfg(i2cra_pkg::CFG_DEVICE_ADDRESS, 10'd127);
        start_transaction(1'b1, 8'h00, 8'h00);
        run_bus(8'hFF, 0, NO_CAP);
        start_transaction(1'b1, 8'h5A, 8'h00);
        run_bus(8'h00, 100, NO_CAP);

        // Zero phase length behaves as one; NACKed write, then a clean one clears the flag.
        write_cfg(i2cra_pkg::CFG_PHASE_TICKS, 10'd0);
        start_transaction(1'b0, 8'hA5, 8'h5A);
        run_bus(8'h00, 100, NO_CAP);
        start_transaction(1'b0, 8'h3C, 8'hC3);
        run_bus(8'h00, 0, NO_CAP);

        // Address changed while the first byte is going out: the repeated start picks it up.
        write_cfg(i2cra_pkg::CFG_PHASE_TICKS, 10'd1);
        start_transaction(1'b1, 8'h81, 8'h7E);
        run_bus(8'h96, 0, 10);
        write_cfg(i2cra_pkg::CFG_DEVICE_ADDRESS, 10'h015);
        run_bus(8'h96, 0, NO_CAP);

        // Longest phase, then cut short mid-phase once the counter is past the new length.
        write_cfg(i2cra_pkg::CFG_DEVICE_ADDRESS, 10'd127);
        write_cfg(i2cra_pkg::CFG_PHASE_TICKS, 10'd1023);
        start_transaction(1'b1, 8'h3C, 8'h00);
        run_bus(8'hC3, 0, 40);
        write_cfg(i2cra_pkg::CFG_PHASE_TICKS, 10'd2);
        run_bus(8'hC3, 0, NO_CAP);

        // Random part: mostly clean transactions with random content, some NACK-heavy.
        goal     = TOTAL_TICKS;
        next_cfg = 0;
        while (sb.ticks_seen < goal) begin
            quiet = (sb.ticks_seen + QUIET_TAIL >= goal);
            if (sb.ticks_seen >= next_cfg) begin
                junk = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 7))
                    0:       dev = '0;
                    1:       dev = '1;
                    default: dev = i2cra_pkg::ADDR_W'($urandom_range(0, 127));
                endcase
                case ($urandom_range(0, 19))
                    0, 1:               plen = 10'd0;
                    2, 3, 4, 5, 6, 7:   plen = 10'd1;
                    8, 9, 10, 11, 12:   plen = 10'd2;
                    13, 14, 15:         plen = 10'd3;
                    default:            plen = i2cra_pkg::PHASE_W'($urandom_range(4, 8));
                endcase
                write_cfg(i2cra_pkg::CFG_DEVICE_ADDRESS, {junk, dev});
                write_cfg(i2cra_pkg::CFG_PHASE_TICKS, plen);
                next_cfg  = sb.ticks_seen + 250;
                tx_idling = !quiet && $urandom_range(0, 3) != 0;
                rx_idling = !quiet && $urandom_range(0, 3) != 0;
                mid_cfg   = !quiet;
                if (!quiet && $urandom_range(0, 1) == 0) begin
                    rx_hold = $urandom_range(30, 80);
                end
            end
            if (quiet) begin
                tx_idling = 1'b0;
                rx_idling = 1'b0;
                mid_cfg   = 1'b0;
            end
            // A few idle ticks with no request between transactions.
            repeat ($urandom_range(0, 3)) begin
                send_tick(1'b0, 1'($urandom_range(0, 1)),
                          i2cra_pkg::BYTE_W'($urandom_range(0, 255)),
                          i2cra_pkg::BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
            kind = $urandom_range(0, 9);
            start_transaction(1'($urandom_range(0, 1)),
                              i2cra_pkg::BYTE_W'($urandom_range(0, 255)),
                              i2cra_pkg::BYTE_W'($urandom_range(0, 255)));
            run_bus(i2cra_pkg::BYTE_W'($urandom_range(0, 255)),
                    (kind == 0) ? 50 : ((kind == 1) ? 10 : 0), NO_CAP);
        end

        // Wind down and report.
        tx_idling = 1'b0;
        drain();
        repeat (4) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
